/* design/lc3s_pkg.sv */
// Shared types, constants and helpers for the LC-3 instruction step unit.
package lc3s_pkg;

  localparam int ADDR_BITS_DEF = 16;

  typedef logic [15:0] word_t;

  // Memory-mapped device words
  localparam word_t DSR_ADDR = 16'hFE04;
  localparam word_t DDR_ADDR = 16'hFE06;
  localparam word_t MCR_ADDR = 16'hFFFE;
  localparam word_t RUN_WORD = 16'h8000;

  // Item actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  // Opcodes
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_RET  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] REG_LINK = 3'd7;

  localparam logic [2:0] FLAG_N = 3'b100;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_P = 3'b001;

  // Main memory write port
  typedef struct packed {
    logic  en;
    word_t addr;
    word_t data;
  } mem_wr_t;

  // Register file write port
  typedef struct packed {
    logic       en;
    logic [2:0] idx;
    word_t      data;
  } rf_wr_t;

  function automatic logic [2:0] flags_of(input word_t v);
    logic [2:0] f;
    if (v == '0) begin
      f = FLAG_Z;
    end else if (v[15]) begin
      f = FLAG_N;
    end else begin
      f = FLAG_P;
    end
    return f;
  endfunction

endpackage

/* design/lc3s_req_if.sv */
// Request channel: one item per beat.
interface lc3s_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  lc3s_pkg::word_t      address;
  lc3s_pkg::word_t      word_data;

  modport source(output valid, output action, output address, output word_data, input ready);
  modport sink(input valid, input action, input address, input word_data, output ready);
endinterface

/* design/lc3s_rsp_if.sv */
// Result channel: one result per beat.
interface lc3s_rsp_if;
  logic            valid;
  logic            ready;
  lc3s_pkg::word_t pc_after;
  lc3s_pkg::word_t instruction;
  logic            char_valid;
  logic [7:0]      char_value;
  logic            halted;
  logic [2:0]      cond_codes;

  modport source(output valid, output pc_after, output instruction, output char_valid,
                 output char_value, output halted, output cond_codes, input ready);
  modport sink(input valid, input pc_after, input instruction, input char_valid,
               input char_value, input halted, input cond_codes, output ready);
endinterface

/* design/lc3s_mem.sv */
// Main memory: one write port, one registered read port, clearing pass after reset.
module lc3s_mem #(
  parameter int ADDR_BITS = lc3s_pkg::ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lc3s_pkg::mem_wr_t      wr,
  input  logic                   rd_en,
  input  logic [ADDR_BITS-1:0]   rd_addr,
  output lc3s_pkg::word_t        rd_data,
  output logic                   busy
);

  localparam int DEPTH = 1 << ADDR_BITS;

  lc3s_pkg::word_t       ram [DEPTH];
  logic [ADDR_BITS:0]    clr_cnt;

  assign busy = !clr_cnt[ADDR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      ram[clr_cnt[ADDR_BITS-1:0]] <= '0;
    end else if (wr.en) begin
      ram[wr.addr[ADDR_BITS-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule

/* design/lc3s_regfile.sv */
// Eight-entry register file: one write port, two registered read ports.
module lc3s_regfile (
  input  logic              clk,
  input  logic              rst,
  input  lc3s_pkg::rf_wr_t  wr,
  input  logic              rd_en,
  input  logic [2:0]        rd_a_idx,
  input  logic [2:0]        rd_b_idx,
  output lc3s_pkg::word_t   rd_a,
  output lc3s_pkg::word_t   rd_b
);

  lc3s_pkg::word_t regs [8];
  logic [7:0]      written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.idx] <= wr.data;
    end
    // an entry never written reads as zero
    if (rd_en) begin
      rd_a <= written[rd_a_idx] ? regs[rd_a_idx] : '0;
      rd_b <= written[rd_b_idx] ? regs[rd_b_idx] : '0;
    end
  end

endmodule

/* design/lc3_instruction_step_unit.sv */
// LC-3 subset core: 64K-word main memory, eight registers, PC and N/Z/P flags.
// After reset the unit clears main memory one word a cycle and takes no request
// until that pass ends. A load, set-start or unknown action finishes in the
// report state after its beat, so such items stream at one per cycle while the
// output register is free. An executed instruction walks fetch, decode and
// execute through the single read port of main memory: BR, ADD, AND, NOT, LEA,
// ST, STR, JSR and RET end in execute, LD, LDR, STI and TRAP add one dependent
// memory read and LDI two, each in a state of its own. A step while the machine
// is halted ends in fetch. Results sit in an output register, and the next
// request is taken in the cycle that the current one finishes.
module lc3_instruction_step_unit #(
  parameter int ADDR_BITS = lc3s_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lc3s_req_if.sink    req,
  lc3s_rsp_if.source  rsp
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_REPORT = 7'b0000010,
    S_FETCH  = 7'b0000100,
    S_DECODE = 7'b0001000,
    S_EXEC   = 7'b0010000,
    S_MEM1   = 7'b0100000,
    S_MEM2   = 7'b1000000
  } state_t;

  state_t state, state_next, work_next;

  // item and architectural state
  logic [1:0]       act_q;
  lc3s_pkg::word_t  addr_q;
  lc3s_pkg::word_t  data_q;
  lc3s_pkg::word_t  pc;
  logic [2:0]       flags;
  lc3s_pkg::word_t  mcr;
  lc3s_pkg::word_t  dsr;
  lc3s_pkg::word_t  ir;
  lc3s_pkg::word_t  rd_addr_q;

  // output register
  logic             out_valid;
  lc3s_pkg::word_t  out_pc;
  lc3s_pkg::word_t  out_ir;
  logic             out_cv;
  logic [7:0]       out_ch;
  logic             out_halted;
  logic [2:0]       out_flags;

  // memory and register file ports
  lc3s_pkg::mem_wr_t mem_wr;
  lc3s_pkg::word_t   ram_q;
  lc3s_pkg::word_t   rd_word;
  lc3s_pkg::word_t   rd_addr;
  logic              rd_en;
  logic              busy;
  lc3s_pkg::rf_wr_t  rf_wr;
  logic              rf_rd_en;
  logic [2:0]        a_idx;
  logic [2:0]        b_idx;
  lc3s_pkg::word_t   ra;
  lc3s_pkg::word_t   rb;

  // per-cycle control
  logic             finish;
  logic             out_free;
  logic             advance;
  logic             accept;
  logic             dsr_arm;
  logic             st_en;
  logic             st_step;
  lc3s_pkg::word_t  st_addr;
  lc3s_pkg::word_t  st_val;
  logic             rf_we;
  logic [2:0]       rf_idx;
  lc3s_pkg::word_t  rf_val;
  logic             flag_we;
  lc3s_pkg::word_t  flag_src;
  lc3s_pkg::word_t  fin_pc;
  lc3s_pkg::word_t  fin_ir;
  logic             emit;
  lc3s_pkg::word_t  mcr_next;

  // decode helpers
  logic [3:0]       op;
  logic [3:0]       fop;
  lc3s_pkg::word_t  pc_inc;
  lc3s_pkg::word_t  ea9;
  lc3s_pkg::word_t  base6;
  lc3s_pkg::word_t  jsr_tgt;
  lc3s_pkg::word_t  operand;
  lc3s_pkg::word_t  alu;

  lc3s_mem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr[ADDR_BITS-1:0]),
    .rd_data (ram_q),
    .busy    (busy)
  );

  lc3s_regfile u_rf (
    .clk      (clk),
    .rst      (rst),
    .wr       (rf_wr),
    .rd_en    (rf_rd_en),
    .rd_a_idx (a_idx),
    .rd_b_idx (b_idx),
    .rd_a     (ra),
    .rd_b     (rb)
  );

  // device words live in registers and shadow their memory entries
  always_comb begin
    if (rd_addr_q == lc3s_pkg::MCR_ADDR) begin
      rd_word = mcr;
    end else if (rd_addr_q == lc3s_pkg::DSR_ADDR) begin
      rd_word = dsr;
    end else begin
      rd_word = ram_q;
    end
  end

  assign op      = ir[15:12];
  assign fop     = rd_word[15:12];
  assign pc_inc  = pc + 16'd1;
  assign ea9     = pc_inc + {{7{ir[8]}}, ir[8:0]};
  assign base6   = ra + {{10{ir[5]}}, ir[5:0]};
  assign jsr_tgt = pc_inc + {{5{ir[10]}}, ir[10:0]};
  assign operand = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rb;
  assign alu     = (op == lc3s_pkg::OP_ADD) ? (ra + operand) : (ra & operand);

  always_comb begin
    finish    = 1'b0;
    work_next = state;
    rd_en     = 1'b0;
    rd_addr   = pc;
    rf_rd_en  = 1'b0;
    a_idx     = rd_word[8:6];
    b_idx     = rd_word[11:9];
    dsr_arm   = 1'b0;
    st_en     = 1'b0;
    st_step   = 1'b0;
    st_addr   = addr_q;
    st_val    = rb;
    rf_we     = 1'b0;
    rf_idx    = ir[11:9];
    rf_val    = rd_word;
    flag_we   = 1'b0;
    flag_src  = rd_word;
    fin_pc    = pc;
    fin_ir    = '0;
    case (state)
      S_IDLE: begin
        work_next = S_IDLE;
      end
      S_REPORT: begin
        finish = 1'b1;
        if (act_q == lc3s_pkg::ACT_LOAD) begin
          st_en   = 1'b1;
          st_addr = addr_q;
          st_val  = data_q;
        end else if (act_q == lc3s_pkg::ACT_START) begin
          st_en   = 1'b1;
          st_addr = lc3s_pkg::MCR_ADDR;
          st_val  = lc3s_pkg::RUN_WORD;
          fin_pc  = addr_q;
        end
      end
      S_FETCH: begin
        if (!mcr[15]) begin
          finish = 1'b1;
        end else begin
          dsr_arm   = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = pc;
          work_next = S_DECODE;
        end
      end
      S_DECODE: begin
        rf_rd_en = 1'b1;
        a_idx    = rd_word[8:6];
        if (fop == lc3s_pkg::OP_RET) begin
          b_idx = lc3s_pkg::REG_LINK;
        end else if (fop == lc3s_pkg::OP_ADD || fop == lc3s_pkg::OP_AND) begin
          b_idx = rd_word[2:0];
        end else begin
          b_idx = rd_word[11:9];
        end
        work_next = S_EXEC;
      end
      S_EXEC: begin
        fin_ir = ir;
        fin_pc = pc_inc;
        case (op)
          lc3s_pkg::OP_BR: begin
            finish = 1'b1;
            if ((ir[11:9] & flags) != 3'b000) begin
              fin_pc = ea9;
            end
          end
          lc3s_pkg::OP_ADD, lc3s_pkg::OP_AND: begin
            finish   = 1'b1;
            rf_we    = 1'b1;
            rf_val   = alu;
            flag_we  = 1'b1;
            flag_src = alu;
          end
          lc3s_pkg::OP_NOT: begin
            finish   = 1'b1;
            rf_we    = 1'b1;
            rf_val   = ~ra;
            flag_we  = 1'b1;
            flag_src = ~ra;
          end
          lc3s_pkg::OP_LEA: begin
            finish   = 1'b1;
            rf_we    = 1'b1;
            rf_val   = ea9;
            flag_we  = 1'b1;
            flag_src = ea9;
          end
          lc3s_pkg::OP_LD, lc3s_pkg::OP_LDI, lc3s_pkg::OP_STI: begin
            rd_en     = 1'b1;
            rd_addr   = ea9;
            work_next = S_MEM1;
          end
          lc3s_pkg::OP_LDR: begin
            rd_en     = 1'b1;
            rd_addr   = base6;
            work_next = S_MEM1;
          end
          lc3s_pkg::OP_TRAP: begin
            rd_en     = 1'b1;
            rd_addr   = {8'h00, ir[7:0]};
            work_next = S_MEM1;
          end
          lc3s_pkg::OP_ST: begin
            finish  = 1'b1;
            st_en   = 1'b1;
            st_step = 1'b1;
            st_addr = ea9;
          end
          lc3s_pkg::OP_STR: begin
            finish  = 1'b1;
            st_en   = 1'b1;
            st_step = 1'b1;
            st_addr = base6;
          end
          lc3s_pkg::OP_JSR: begin
            finish = 1'b1;
            rf_we  = 1'b1;
            rf_idx = lc3s_pkg::REG_LINK;
            rf_val = pc_inc;
            fin_pc = jsr_tgt;
          end
          lc3s_pkg::OP_RET: begin
            finish = 1'b1;
            fin_pc = rb;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_MEM1: begin
        fin_ir = ir;
        fin_pc = pc_inc;
        case (op)
          lc3s_pkg::OP_LDI: begin
            rd_en     = 1'b1;
            rd_addr   = rd_word;
            work_next = S_MEM2;
          end
          lc3s_pkg::OP_STI: begin
            finish  = 1'b1;
            st_en   = 1'b1;
            st_step = 1'b1;
            st_addr = rd_word;
          end
          lc3s_pkg::OP_TRAP: begin
            finish = 1'b1;
            rf_we  = 1'b1;
            rf_idx = lc3s_pkg::REG_LINK;
            rf_val = pc_inc;
            fin_pc = rd_word;
          end
          default: begin
            // LD and LDR
            finish  = 1'b1;
            rf_we   = 1'b1;
            flag_we = 1'b1;
          end
        endcase
      end
      S_MEM2: begin
        fin_ir  = ir;
        fin_pc  = pc_inc;
        finish  = 1'b1;
        rf_we   = 1'b1;
        flag_we = 1'b1;
      end
      default: begin
        work_next = S_IDLE;
      end
    endcase
  end

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = finish && out_free;
  assign req.ready = !busy && out_free && (state == S_IDLE || finish);
  assign accept    = req.valid && req.ready;

  assign emit     = st_en && st_step && (st_addr == lc3s_pkg::DDR_ADDR) && dsr[15];
  assign mcr_next = (st_en && st_addr == lc3s_pkg::MCR_ADDR) ? st_val : mcr;

  assign mem_wr = '{en: advance && st_en, addr: st_addr, data: st_val};
  assign rf_wr  = '{en: advance && rf_we, idx: rf_idx, data: rf_val};

  always_comb begin
    if (accept) begin
      state_next = (req.action == lc3s_pkg::ACT_STEP) ? S_FETCH : S_REPORT;
    end else if (advance) begin
      state_next = S_IDLE;
    end else if (finish) begin
      state_next = state;
    end else begin
      state_next = work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      flags     <= lc3s_pkg::FLAG_P;
      mcr       <= '0;
      dsr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        pc  <= fin_pc;
        mcr <= mcr_next;
        if (flag_we) begin
          flags <= lc3s_pkg::flags_of(flag_src);
        end
      end
      // arm the display at step start, clear it once a character goes out, else take a store to DSR
      if (dsr_arm) begin
        dsr <= lc3s_pkg::RUN_WORD;
      end else if (advance && emit) begin
        dsr <= '0;
      end else if (advance && st_en && st_addr == lc3s_pkg::DSR_ADDR) begin
        dsr <= st_val;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= req.action;
      addr_q <= req.address;
      data_q <= req.word_data;
    end
    if (state == S_DECODE) begin
      ir <= rd_word;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (advance) begin
      out_pc     <= fin_pc;
      out_ir     <= fin_ir;
      out_cv     <= emit;
      out_ch     <= emit ? st_val[7:0] : 8'h00;
      out_halted <= !mcr_next[15];
      out_flags  <= flag_we ? lc3s_pkg::flags_of(flag_src) : flags;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pc_after    = out_pc;
  assign rsp.instruction = out_ir;
  assign rsp.char_valid  = out_cv;
  assign rsp.char_value  = out_ch;
  assign rsp.halted      = out_halted;
  assign rsp.cond_codes  = out_flags;

endmodule

/* tb/sv/tb_lc3_instruction_step_unit.sv */
// Self-checking testbench for the LC-3 instruction step unit: random programs, stalls, drains.
module tb_lc3_instruction_step_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef lc3s_pkg::word_t word_t;

  localparam logic [1:0] ACT_NONE  = 2'd3;
  localparam logic [3:0] OP_RTI    = 4'd8;
  localparam logic [3:0] OP_RES    = 4'd13;
  localparam logic [2:0] REG_PTR   = 3'd6;
  localparam int         CYCLE_CAP = 600000;
  localparam int         HOLD_AT   = 120;
  localparam int         HOLD_LEN  = 400;

  typedef struct {
    logic [1:0] action;
    word_t      address;
    word_t      word_data;
    bit         drain;
  } lc3_item_t;

  typedef struct {
    word_t      pc_after;
    word_t      instruction;
    logic       char_valid;
    logic [7:0] char_value;
    logic       halted;
    logic [2:0] cond_codes;
  } machine_state_t;

  logic clk;
  logic rst;

  lc3s_req_if req_bus ();
  lc3s_rsp_if rsp_bus ();

  lc3_instruction_step_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow machine
  word_t      mem_image [0:65535];
  word_t      gpr [0:7];
  word_t      pc_reg;
  logic [2:0] nzp;

  lc3_item_t      items_to_send[$];
  machine_state_t machine_states_due[$];

  int  req_beats  = 0;
  int  rsp_beats  = 0;
  int  sent_seen  = 0;
  int  rsp_seen   = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 0;
  int  mismatches = 0;
  int  cycles     = 0;
  int  total_items;
  bit  pause_next = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic lc3_execute(input logic [1:0] act, input word_t addr, input word_t data,
                             output machine_state_t r);
    word_t      ir, pc, ea, v, st_addr;
    logic [3:0] op;
    logic [2:0] dr, sr1;
    bit         sets_cc, stores;
    ir = '0;
    r.char_valid = 1'b0;
    r.char_value = '0;
    case (act)
      lc3s_pkg::ACT_LOAD: begin
        mem_image[addr] = data;
      end
      lc3s_pkg::ACT_START: begin
        pc_reg = addr;
        mem_image[lc3s_pkg::MCR_ADDR] = lc3s_pkg::RUN_WORD;
      end
      lc3s_pkg::ACT_STEP: begin
        if (mem_image[lc3s_pkg::MCR_ADDR][15]) begin
          mem_image[lc3s_pkg::DSR_ADDR] = lc3s_pkg::RUN_WORD;
          ir = mem_image[pc_reg];
          pc = pc_reg + 16'd1;
          op = ir[15:12];
          dr = ir[11:9];
          sr1 = ir[8:6];
          ea = pc + {{7{ir[8]}}, ir[8:0]};
          v = '0;
          st_addr = '0;
          sets_cc = 0;
          stores = 0;
          case (op)
            lc3s_pkg::OP_BR: begin
              if ((ir[11:9] & nzp) != 3'b000) pc = ea;
            end
            lc3s_pkg::OP_ADD, lc3s_pkg::OP_AND: begin
              v = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[ir[2:0]];
              v = (op == lc3s_pkg::OP_ADD) ? gpr[sr1] + v : gpr[sr1] & v;
              sets_cc = 1;
            end
            lc3s_pkg::OP_NOT: begin
              v = ~gpr[sr1];
              sets_cc = 1;
            end
            lc3s_pkg::OP_LD: begin
              v = mem_image[ea];
              sets_cc = 1;
            end
            lc3s_pkg::OP_LDI: begin
              v = mem_image[mem_image[ea]];
              sets_cc = 1;
            end
            lc3s_pkg::OP_LEA: begin
              v = ea;
              sets_cc = 1;
            end
            lc3s_pkg::OP_LDR: begin
              v = mem_image[gpr[sr1] + {{10{ir[5]}}, ir[5:0]}];
              sets_cc = 1;
            end
            lc3s_pkg::OP_ST: begin
              st_addr = ea;
              stores = 1;
            end
            lc3s_pkg::OP_STI: begin
              st_addr = mem_image[ea];
              stores = 1;
            end
            lc3s_pkg::OP_STR: begin
              st_addr = gpr[sr1] + {{10{ir[5]}}, ir[5:0]};
              stores = 1;
            end
            lc3s_pkg::OP_JSR: begin
              gpr[lc3s_pkg::REG_LINK] = pc;
              pc = pc + {{5{ir[10]}}, ir[10:0]};
            end
            lc3s_pkg::OP_RET: begin
              pc = gpr[lc3s_pkg::REG_LINK];
            end
            lc3s_pkg::OP_TRAP: begin
              gpr[lc3s_pkg::REG_LINK] = pc;
              pc = mem_image[{8'h00, ir[7:0]}];
            end
            default: ;
          endcase
          if (sets_cc) begin
            gpr[dr] = v;
            if (v == '0) nzp = lc3s_pkg::FLAG_Z;
            else if (v[15]) nzp = lc3s_pkg::FLAG_N;
            else nzp = lc3s_pkg::FLAG_P;
          end
          if (stores) begin
            mem_image[st_addr] = gpr[dr];
            // emit only while the display reports ready, then mark it busy
            if (st_addr == lc3s_pkg::DDR_ADDR && mem_image[lc3s_pkg::DSR_ADDR][15]) begin
              r.char_valid = 1'b1;
              r.char_value = mem_image[lc3s_pkg::DDR_ADDR][7:0];
              mem_image[lc3s_pkg::DSR_ADDR] = '0;
            end
          end
          pc_reg = pc;
        end
      end
      default: ;
    endcase
    r.pc_after = pc_reg;
    r.instruction = ir;
    r.halted = ~mem_image[lc3s_pkg::MCR_ADDR][15];
    r.cond_codes = nzp;
  endtask

  task automatic queue_item(input logic [1:0] act, input word_t addr, input word_t data);
    lc3_item_t it;
    it.action = act;
    it.address = addr;
    it.word_data = data;
    it.drain = pause_next;
    pause_next = 0;
    items_to_send.push_back(it);
  endtask

  task automatic check_field(input string label, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Request driver
  always @(negedge clk) begin : driver
    lc3_item_t it;
    bit        accepted;
    if (!rst) begin
      accepted = (req_beats != sent_seen);
      if (accepted) begin
        sent_seen = req_beats;
        gap_left = ((sent_seen / 50) % 4 == 3) ? 0 : $urandom_range(0, 12);
      end
      // hold the beat until it is taken
      if (!req_bus.valid || accepted) begin
        if (gap_left > 0) begin
          req_bus.valid <= 1'b0;
          gap_left--;
        end else if (items_to_send.size() != 0 &&
                     !(items_to_send[0].drain && machine_states_due.size() != 0)) begin
          it = items_to_send.pop_front();
          req_bus.action    <= it.action;
          req_bus.address   <= it.address;
          req_bus.word_data <= it.word_data;
          req_bus.valid     <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_beats != rsp_seen) begin
        rsp_seen = rsp_beats;
        stall_left = ((rsp_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 12);
      end
      if (!hold_done && rsp_seen >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each request beat, check each result beat
  always @(posedge clk) begin : monitor
    machine_state_t due;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_beats++;
        if (machine_states_due.size() == 0) begin
          $display("%0t: unexpected result pc_after 0x%0h instruction 0x%0h", $time,
                   rsp_bus.pc_after, rsp_bus.instruction);
          mismatches++;
        end else begin
          due = machine_states_due.pop_front();
          check_field("pc_after", due.pc_after, rsp_bus.pc_after);
          check_field("instruction", due.instruction, rsp_bus.instruction);
          check_field("char_valid", 16'(due.char_valid), 16'(rsp_bus.char_valid));
          check_field("char_value", 16'(due.char_value), 16'(rsp_bus.char_value));
          check_field("halted", 16'(due.halted), 16'(rsp_bus.halted));
          check_field("cond_codes", 16'(due.cond_codes), 16'(rsp_bus.cond_codes));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        lc3_execute(req_bus.action, req_bus.address, req_bus.word_data, due);
        machine_states_due.push_back(due);
        req_beats++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int         seg, len, i, k, pick;
    word_t      base, w;
    logic [2:0] r;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.action = lc3s_pkg::ACT_LOAD;
    req_bus.address = '0;
    req_bus.word_data = '0;
    rsp_bus.ready = 1'b0;
    for (i = 0; i < 65536; i++) mem_image[i] = '0;
    for (i = 0; i < 8; i++) gpr[i] = '0;
    pc_reg = '0;
    nzp = lc3s_pkg::FLAG_P;

    // Directed: halted step, unknown action, wrap at the top of memory,
    // display output via STI, trap, spare opcodes, halt by a store to MCR
    queue_item(lc3s_pkg::ACT_STEP, 16'hFFFF, 16'hFFFF);
    queue_item(ACT_NONE, 16'hFFFF, 16'hFFFF);
    queue_item(lc3s_pkg::ACT_LOAD, 16'hFFFF, {lc3s_pkg::OP_ADD, 3'd1, 3'd0, 1'b1, 5'b10000});
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0000, {lc3s_pkg::OP_STI, 3'd1, 9'd1});
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0001, {OP_RTI, 12'hFFF});
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0002, lc3s_pkg::DDR_ADDR);
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0006, 16'h0010);
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0010, {OP_RES, 12'h000});
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0011, {lc3s_pkg::OP_STR, 3'd0, 3'd2, 6'b111110});
    queue_item(lc3s_pkg::ACT_START, 16'hFFFF, 16'h0000);
    repeat (7) queue_item(lc3s_pkg::ACT_STEP, 16'h0000, 16'h0000);
    queue_item(ACT_NONE, 16'h0000, 16'h0000);
    queue_item(lc3s_pkg::ACT_LOAD, 16'h0000, 16'h0000);

    // Random programs: LD R6 with the display address, then mixed words with
    // a bias to display stores, followed by pointer words and steps
    pause_next = 1;
    seg = 0;
    while (items_to_send.size() < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 8))
          queue_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end else begin
        base = ($urandom_range(0, 7) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                           : 16'($urandom);
        len = $urandom_range(3, 12);
        queue_item(lc3s_pkg::ACT_LOAD, base, {lc3s_pkg::OP_LD, REG_PTR, 9'(len)});
        for (i = 1; i <= len; i++) begin
          pick = $urandom_range(0, 19);
          r = 3'($urandom_range(0, 7));
          if (pick < 3) begin
            w = {lc3s_pkg::OP_STR, r, REG_PTR, 6'd0};
          end else if (pick < 5) begin
            k = ($urandom_range(0, 3) == 0) ? 1 : 0;
            w = {lc3s_pkg::OP_STI, r, 9'(len - i + k)};
          end else if (pick == 5) begin
            w = {lc3s_pkg::OP_LDI, r, 9'(len - i + 2)};
          end else begin
            w = 16'($urandom);
          end
          queue_item(lc3s_pkg::ACT_LOAD, base + 16'(i), w);
        end
        queue_item(lc3s_pkg::ACT_LOAD, base + 16'(len + 1), lc3s_pkg::DDR_ADDR);
        queue_item(lc3s_pkg::ACT_LOAD, base + 16'(len + 2), lc3s_pkg::MCR_ADDR);
        queue_item(lc3s_pkg::ACT_LOAD, base + 16'(len + 3), 16'($urandom));
        if ($urandom_range(0, 9) != 0) queue_item(lc3s_pkg::ACT_START, base, 16'($urandom));
        repeat (len + $urandom_range(1, 6))
          queue_item(lc3s_pkg::ACT_STEP, 16'($urandom), 16'($urandom));
      end
      seg++;
      if (seg % 6 == 5) pause_next = 1;
    end
    total_items = items_to_send.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rsp_beats != total_items || machine_states_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
